FILE: sv/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/tclg_pkg.sv
// types, constants and cell-rule functions of the two-colour life generation core
package tclg_pkg;

   localparam int WIDTH_MAX    = 32;
   localparam int HEIGHT_MAX   = 32;
   localparam int COL_W        = $clog2(WIDTH_MAX);
   localparam int ROW_W        = $clog2(HEIGHT_MAX);
   localparam int CFG_W        = 6;
   localparam int SEED_W       = 16;
   localparam int OUT_COL_W    = 5;
   localparam int OUT_ROW_W    = 5;
   localparam int CSR_IDX_W    = 2;

   localparam logic [SEED_W-1:0] SEED_DEFAULT = 16'hACE1;
   localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;
   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 6'd32;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 6'd18;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd2;

   typedef struct packed {
      logic cell_alive;
      logic cell_colour;
   } req_type;

   typedef struct packed {
      logic                 next_alive;
      logic                 next_colour;
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 frame_last;
   } rsp_type;

   // three-cell column: alive count, colour count, middle cell
   typedef struct packed {
      logic [1:0] alive;
      logic [1:0] colour;
      logic [1:0] mid;
   } col_sum_type;

   localparam col_sum_type SUM_ZERO = '0;

   typedef struct packed {
      logic alive;
      logic colour;
      logic tie;
   } cell_next_type;

   typedef struct packed {
      logic accept;
      logic edge_emit;
      logic flush_load;
      logic flush_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic emit_first;
      logic row_end;
      logic frame_end;
      logic flush_end;
   } stat_type;

   // cells are {colour, alive}
   function automatic col_sum_type make_sum(logic [1:0] top, logic [1:0] mid,
                                            logic [1:0] bot);
      col_sum_type s;
      s.alive  = {1'b0, top[0]} + {1'b0, mid[0]} + {1'b0, bot[0]};
      s.colour = {1'b0, top[1]} + {1'b0, mid[1]} + {1'b0, bot[1]};
      s.mid    = mid;
      return s;
   endfunction

   function automatic logic [COL_W-1:0] width_last(logic [CFG_W-1:0] v);
      logic [COL_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > WIDTH_MAX) begin
         res = COL_W'(WIDTH_MAX - 1);
      end else begin
         res = COL_W'(v - CFG_W'(1));
      end
      return res;
   endfunction

   function automatic logic [ROW_W-1:0] height_last(logic [CFG_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > HEIGHT_MAX) begin
         res = ROW_W'(HEIGHT_MAX - 1);
      end else begin
         res = ROW_W'(v - CFG_W'(1));
      end
      return res;
   endfunction

   function automatic cell_next_type next_cell(col_sum_type l, col_sum_type c,
                                               col_sum_type r, logic rnd);
      cell_next_type res;
      logic [3:0]    total;
      logic [3:0]    p2;
      logic          major;
      total = 4'(l.alive) + 4'(c.alive) + 4'(r.alive) - 4'(c.mid[0]);
      p2    = 4'(l.colour) + 4'(c.colour) + 4'(r.colour) - 4'(c.mid[1]);
      major = ({p2, 1'b0} > {1'b0, total});
      res   = '0;
      if (total == 4'd2 && p2 == 4'd1) begin
         res.tie    = 1'b1;
         res.alive  = c.mid[0];
         res.colour = rnd;
      end else if ((c.mid[0] && (total == 4'd2 || total == 4'd3)) ||
                   (!c.mid[0] && total == 4'd3)) begin
         res.alive  = 1'b1;
         res.colour = major;
      end
      return res;
   endfunction

   function automatic logic [SEED_W-1:0] lfsr_step(logic [SEED_W-1:0] v);
      return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
   endfunction

endpackage

FILE: sv/tclg_ctrl.sv
// controller state machine: item intake, row-end emission and final-row flush
module tclg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tclg_pkg::stat_type stat,
   output tclg_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_RUN   = 2'd0;
   localparam logic [1:0] S_EDGE  = 2'd1;
   localparam logic [1:0] S_FLOAD = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       last_pend_ff, last_pend_in;

   always_comb begin
      state_in     = state_ff;
      last_pend_in = last_pend_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_RUN: begin
            req_stall  = !stat.out_free;
            cmd.accept = req_valid && stat.out_free;
            if (cmd.accept) begin
               if (stat.row_end) begin
                  state_in     = S_EDGE;
                  last_pend_in = stat.frame_end;
               end else if (stat.frame_end) begin
                  state_in = S_FLOAD;
               end
            end
         end
         S_EDGE: begin
            if (stat.out_free) begin
               cmd.edge_emit = 1'b1;
               state_in      = last_pend_ff ? S_FLOAD : S_RUN;
            end
         end
         S_FLOAD: begin
            cmd.flush_load = 1'b1;
            state_in       = S_FLUSH;
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_emit = 1'b1;
               if (stat.flush_end) begin
                  state_in = S_RUN;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         last_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_pend_ff <= last_pend_in;
      end
   end

endmodule

FILE: sv/tclg_dp.sv
// datapath: line buffers, column windows, cell rule, tie lfsr and result register
module tclg_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tclg_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tclg_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic [tclg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tclg_pkg::SEED_W-1:0]          csr_wdata,
   input  tclg_pkg::cmd_type                    cmd,
   output tclg_pkg::stat_type                   stat
);

   logic [tclg_pkg::CFG_W-1:0]  width_ff, width_in;
   logic [tclg_pkg::CFG_W-1:0]  height_ff, height_in;
   logic [tclg_pkg::SEED_W-1:0] lfsr_ff, lfsr_in;

   logic [1:0] older_ff [tclg_pkg::WIDTH_MAX];
   logic [1:0] newer_ff [tclg_pkg::WIDTH_MAX];

   logic [tclg_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [tclg_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [tclg_pkg::COL_W-1:0] acc_col_ff, acc_col_in;
   logic [tclg_pkg::ROW_W-1:0] acc_row_ff, acc_row_in;
   logic [tclg_pkg::COL_W-1:0] flush_x_ff, flush_x_in;

   tclg_pkg::col_sum_type win_far_ff, win_far_in;
   tclg_pkg::col_sum_type win_near_ff, win_near_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tclg_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic [tclg_pkg::COL_W-1:0] wm1, c, rd_addr, emit_col;
   logic [tclg_pkg::ROW_W-1:0] hm1, r, emit_row;
   logic [1:0]                 older_rd, newer_rd, cell_in;
   logic                       top_ok, emit_last, do_emit;
   tclg_pkg::col_sum_type      cur, right, centre0, emit_right;
   tclg_pkg::cell_next_type    nc;

   assign wm1 = tclg_pkg::width_last(width_ff);
   assign hm1 = tclg_pkg::height_last(height_ff);
   assign c   = (in_col_ff > wm1) ? wm1 : in_col_ff;
   assign r   = (in_row_ff > hm1) ? hm1 : in_row_ff;

   always_comb begin
      priority if (cmd.flush_load) begin
         rd_addr = '0;
      end else if (cmd.flush_emit) begin
         rd_addr = flush_x_ff + tclg_pkg::COL_W'(1);
      end else begin
         rd_addr = c;
      end
   end

   assign older_rd = older_ff[rd_addr];
   assign newer_rd = newer_ff[rd_addr];
   assign cell_in  = {req_data.cell_colour, req_data.cell_alive};
   assign top_ok   = (acc_row_ff != '0);

   assign cur     = tclg_pkg::make_sum((r >= tclg_pkg::ROW_W'(2)) ? older_rd : 2'b00,
                                       (r != '0) ? newer_rd : 2'b00, cell_in);
   assign centre0 = tclg_pkg::make_sum(top_ok ? older_rd : 2'b00, newer_rd, 2'b00);
   assign right   = (flush_x_ff != wm1) ? centre0 : tclg_pkg::SUM_ZERO;

   // one emission per cycle while the result register is free; left and centre always come from the window
   always_comb begin
      priority if (cmd.accept) begin
         emit_right = cur;
         emit_row   = r - tclg_pkg::ROW_W'(1);
         emit_col   = c - tclg_pkg::COL_W'(1);
         emit_last  = 1'b0;
      end else if (cmd.edge_emit) begin
         emit_right = tclg_pkg::SUM_ZERO;
         emit_row   = acc_row_ff - tclg_pkg::ROW_W'(1);
         emit_col   = acc_col_ff;
         emit_last  = 1'b0;
      end else begin
         emit_right = right;
         emit_row   = acc_row_ff;
         emit_col   = flush_x_ff;
         emit_last  = (flush_x_ff == wm1);
      end
   end

   assign nc      = tclg_pkg::next_cell(win_far_ff, win_near_ff, emit_right, lfsr_ff[0]);
   assign do_emit = (cmd.accept && stat.emit_first) || cmd.edge_emit || cmd.flush_emit;

   always_comb begin
      rsp_valid_in            = do_emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in             = rsp_data_ff;
      if (do_emit) begin
         rsp_data_in.next_alive  = nc.alive;
         rsp_data_in.next_colour = nc.colour;
         rsp_data_in.out_col     = tclg_pkg::OUT_COL_W'(emit_col);
         rsp_data_in.out_row     = tclg_pkg::OUT_ROW_W'(emit_row);
         rsp_data_in.frame_last  = emit_last;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      lfsr_in   = lfsr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tclg_pkg::CSR_WIDTH:  width_in  = csr_wdata[tclg_pkg::CFG_W-1:0];
            tclg_pkg::CSR_HEIGHT: height_in = csr_wdata[tclg_pkg::CFG_W-1:0];
            tclg_pkg::CSR_SEED: begin
               lfsr_in = (csr_wdata != '0) ? csr_wdata : tclg_pkg::SEED_DEFAULT;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end else if (do_emit && nc.tie) begin
         lfsr_in = tclg_pkg::lfsr_step(lfsr_ff);
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      acc_col_in  = acc_col_ff;
      acc_row_in  = acc_row_ff;
      flush_x_in  = flush_x_ff;
      win_far_in  = win_far_ff;
      win_near_in = win_near_ff;
      priority if (cmd.accept) begin
         acc_col_in  = c;
         acc_row_in  = r;
         win_far_in  = (c == '0) ? tclg_pkg::SUM_ZERO : win_near_ff;
         win_near_in = cur;
         if (stat.frame_end) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (c == wm1) begin
            in_col_in = '0;
            in_row_in = r + tclg_pkg::ROW_W'(1);
         end else begin
            in_col_in = c + tclg_pkg::COL_W'(1);
         end
      end else if (cmd.flush_load) begin
         flush_x_in  = '0;
         win_far_in  = tclg_pkg::SUM_ZERO;
         win_near_in = centre0;
      end else if (cmd.flush_emit) begin
         flush_x_in  = flush_x_ff + tclg_pkg::COL_W'(1);
         win_far_in  = win_near_ff;
         win_near_in = right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= tclg_pkg::WIDTH_RESET;
         height_ff    <= tclg_pkg::HEIGHT_RESET;
         lfsr_ff      <= tclg_pkg::SEED_DEFAULT;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         lfsr_ff      <= lfsr_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_col_ff  <= acc_col_in;
      acc_row_ff  <= acc_row_in;
      flush_x_ff  <= flush_x_in;
      win_far_ff  <= win_far_in;
      win_near_ff <= win_near_in;
      rsp_data_ff <= rsp_data_in;
   end

   // line buffers shift one row down as the new row arrives
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         older_ff[c] <= newer_rd;
         newer_ff[c] <= cell_in;
      end
   end

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.emit_first = (r != '0) && (c != '0);
   assign stat.row_end    = (r != '0) && (c == wm1);
   assign stat.frame_end  = (r == hm1) && (c == wm1);
   assign stat.flush_end  = (flush_x_ff == wm1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/two_colour_life_generation_core.sv
// Two-colour life generation core: takes one generation as a raster stream of
// cells (row 0 first, column 0 first) and returns the next generation in raster
// order, one row behind the input, with no wrap at the grid border. Inside a row
// one cell is taken per clock while the result register drains; the last cell of
// every row but the first is followed by a right-edge result, and the last cell
// of a frame is followed by a setup state and a flush of the final row from the
// line buffers. Input is held off during the edge, setup and flush states and
// whenever the result register is full and stalled. Width, height and seed must
// be written through the csr port only while the block is idle; the block itself
// does not enforce this. Writing the seed reloads the tie-break lfsr, a zero seed
// loading 0xACE1.
module two_colour_life_generation_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tclg_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tclg_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tclg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tclg_pkg::SEED_W-1:0]    csr_wdata
);

   tclg_pkg::cmd_type  cmd;
   tclg_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tclg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tclg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

FILE: sv/tclg_checker.sv
// port-level checker for the two-colour life generation core and its bind
`include "assert_macros.svh"

module tclg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tclg_pkg::rsp_type rsp_data
);

   logic rsp_held;

   assign rsp_held = rsp_valid && rsp_stall;

   `ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_held, rsp_valid)
   `ASSERT_NEXT(rsp_data_holds, clock, reset, rsp_held, $stable(rsp_data))
   `ASSERT_IMPLIES(full_blocks_input, clock, reset, rsp_held, req_stall)
   `ASSERT_NEXT_ALWAYS(reset_clears_rsp, clock, reset, !rsp_valid)

endmodule

bind two_colour_life_generation_core tclg_checker u_tclg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/two_colour_life_generation_checker.sv
// checker: predicts the next generation from the observed cell beats and compares result beats
`timescale 1ns / 1ps
module two_colour_life_generation_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tclg_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tclg_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [tclg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tclg_pkg::SEED_W-1:0]    csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);

   typedef struct {
      int         alive;
      int         colour;
      logic [1:0] mid;
   } column_type;

   logic [tclg_pkg::CFG_W-1:0]  width_reg;
   logic [tclg_pkg::CFG_W-1:0]  height_reg;
   logic [tclg_pkg::SEED_W-1:0] tie_lfsr;
   logic [1:0]                  older_row [tclg_pkg::WIDTH_MAX];
   logic [1:0]                  newer_row [tclg_pkg::WIDTH_MAX];
   int                          in_col;
   int                          in_row;
   column_type                  win_far;
   column_type                  win_near;
   tclg_pkg::rsp_type           next_gen_q [$];
   int                          mismatches;

   function automatic column_type column_of(logic [1:0] top, logic [1:0] mid,
                                            logic [1:0] bot);
      column_type s;
      s.alive  = int'(top[0]) + int'(mid[0]) + int'(bot[0]);
      s.colour = int'(top[1]) + int'(mid[1]) + int'(bot[1]);
      s.mid    = mid;
      return s;
   endfunction

   function automatic int clamp_dim(logic [tclg_pkg::CFG_W-1:0] v, int most);
      if (v == '0) return 1;
      if (int'(v) > most) return most;
      return int'(v);
   endfunction

   // applies the life rule to one cell and queues its expected beat
   function automatic void emit_next(column_type l, column_type c, column_type r,
                                     int row, int col, logic last);
      int                alive_n;
      int                colour_n;
      tclg_pkg::rsp_type e;
      alive_n  = l.alive + c.alive + r.alive - int'(c.mid[0]);
      colour_n = l.colour + c.colour + r.colour - int'(c.mid[1]);
      e            = '0;
      e.out_col    = tclg_pkg::OUT_COL_W'(col);
      e.out_row    = tclg_pkg::OUT_ROW_W'(row);
      e.frame_last = last;
      if (alive_n == 2 && colour_n == 1) begin
         e.next_alive  = c.mid[0];
         e.next_colour = tie_lfsr[0];
         tie_lfsr      = (tie_lfsr >> 1) ^ (tie_lfsr[0] ? tclg_pkg::LFSR_TAPS : '0);
      end else if ((c.mid[0] && (alive_n == 2 || alive_n == 3)) ||
                   (!c.mid[0] && alive_n == 3)) begin
         e.next_alive  = 1'b1;
         e.next_colour = (colour_n > alive_n - colour_n);
      end
      next_gen_q.push_back(e);
   endfunction

   function automatic void predict_cell(tclg_pkg::req_type site);
      int         w;
      int         h;
      int         c;
      int         r;
      logic [1:0] now_cell;
      logic [1:0] top;
      logic [1:0] mid;
      column_type cur;
      column_type left;
      column_type centre;
      column_type right;
      w = clamp_dim(width_reg, tclg_pkg::WIDTH_MAX);
      h = clamp_dim(height_reg, tclg_pkg::HEIGHT_MAX);
      if (in_col > w - 1) in_col = w - 1;
      if (in_row > h - 1) in_row = h - 1;
      c        = in_col;
      r        = in_row;
      now_cell = {site.cell_colour, site.cell_alive};
      top      = (r >= 2) ? older_row[c] : 2'b00;
      mid      = (r >= 1) ? newer_row[c] : 2'b00;
      older_row[c] = newer_row[c];
      newer_row[c] = now_cell;
      cur = column_of(top, mid, now_cell);
      if (c == 0) win_near = column_of(2'b00, 2'b00, 2'b00);
      if (r >= 1 && c >= 1) emit_next(win_far, win_near, cur, r - 1, c - 1, 1'b0);
      if (r >= 1 && c == w - 1) begin
         emit_next(win_near, cur, column_of(2'b00, 2'b00, 2'b00), r - 1, c, 1'b0);
      end
      win_far  = win_near;
      win_near = cur;
      if (r == h - 1 && c == w - 1) begin
         // last row leaves from the line buffers with an empty row below
         left   = column_of(2'b00, 2'b00, 2'b00);
         centre = column_of((r >= 1) ? older_row[0] : 2'b00, newer_row[0], 2'b00);
         for (int x = 0; x < w; x++) begin
            right = column_of(2'b00, 2'b00, 2'b00);
            if (x + 1 < w) begin
               right = column_of((r >= 1) ? older_row[x+1] : 2'b00, newer_row[x+1], 2'b00);
            end
            emit_next(left, centre, right, r, x, x == w - 1);
            left   = centre;
            centre = right;
         end
         in_col = 0;
         in_row = 0;
      end else if (c == w - 1) begin
         in_col = 0;
         in_row = r + 1;
      end else begin
         in_col = c + 1;
      end
   endfunction

   function automatic void clear_model();
      width_reg  = tclg_pkg::WIDTH_RESET;
      height_reg = tclg_pkg::HEIGHT_RESET;
      tie_lfsr   = tclg_pkg::SEED_DEFAULT;
      for (int i = 0; i < tclg_pkg::WIDTH_MAX; i++) begin
         older_row[i] = 2'b00;
         newer_row[i] = 2'b00;
      end
      in_col   = 0;
      in_row   = 0;
      win_far  = column_of(2'b00, 2'b00, 2'b00);
      win_near = column_of(2'b00, 2'b00, 2'b00);
      next_gen_q.delete();
      mismatches = 0;
   endfunction

   always @(posedge clock) begin : watch
      tclg_pkg::rsp_type want;
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tclg_pkg::CSR_WIDTH: begin
                  width_reg = csr_wdata[tclg_pkg::CFG_W-1:0];
               end
               tclg_pkg::CSR_HEIGHT: begin
                  height_reg = csr_wdata[tclg_pkg::CFG_W-1:0];
               end
               tclg_pkg::CSR_SEED: begin
                  tie_lfsr = (csr_wdata == '0) ? tclg_pkg::SEED_DEFAULT : csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) predict_cell(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (next_gen_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result beat: row %0d col %0d alive %b colour %b last %b",
                           rsp_data.out_row, rsp_data.out_col, rsp_data.next_alive,
                           rsp_data.next_colour, rsp_data.frame_last);
               end
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_data.next_alive !== want.next_alive ||
                   rsp_data.next_colour !== want.next_colour ||
                   rsp_data.out_col !== want.out_col ||
                   rsp_data.out_row !== want.out_row ||
                   rsp_data.frame_last !== want.frame_last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch: expected row %0d col %0d alive %b %s %b %s %b",
                              want.out_row, want.out_col, want.next_alive, "colour",
                              want.next_colour, "last", want.frame_last);
                     $display("                 actual   row %0d col %0d alive %b %s %b %s %b",
                              rsp_data.out_row, rsp_data.out_col, rsp_data.next_alive,
                              "colour", rsp_data.next_colour, "last",
                              rsp_data.frame_last);
                  end
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= next_gen_q.size();
   end

endmodule

FILE: tb/sv/tb_two_colour_life_generation_core.sv
// testbench top: drives cell frames and register writes into the core and reports the verdict
`timescale 1ns / 1ps
module tb_two_colour_life_generation_core;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 48;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_CELLS  = 140;
   // rows of {alive, colour}: live and dead cells on a tie, a birth and a survivor
   localparam logic [17:0] MIXED_3X3 = 18'b10_11_01_00_10_00_01_00_11;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   tclg_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b1;
   tclg_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tclg_pkg::CSR_IDX_W-1:0] csr_index = tclg_pkg::CSR_WIDTH;
   logic [tclg_pkg::SEED_W-1:0]    csr_wdata = '0;
   int                             fail_count;
   int                             pending_count;
   bit                             send_burst = 1'b0;
   bit                             hold_rsp   = 1'b0;
   logic                           moved;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   two_colour_life_generation_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   two_colour_life_generation_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   assign moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                  (csr_valid && csr_ready);

   task automatic send_cell(tclg_pkg::req_type site);
      int gap;
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= site;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_frame();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [tclg_pkg::CSR_IDX_W-1:0] idx,
                            logic [tclg_pkg::SEED_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(logic [tclg_pkg::CFG_W-1:0] w_raw,
                            logic [tclg_pkg::CFG_W-1:0] h_raw,
                            logic [tclg_pkg::SEED_W-1:0] seed, bit load_seed);
      write_reg(tclg_pkg::CSR_WIDTH, {10'($urandom_range(0, 1023)), w_raw});
      write_reg(tclg_pkg::CSR_HEIGHT, {10'($urandom_range(0, 1023)), h_raw});
      if (load_seed) write_reg(tclg_pkg::CSR_SEED, seed);
      csr_valid <= 1'b0;
   endtask

   task automatic random_frame(int cells);
      int                density;
      tclg_pkg::req_type site;
      density = $urandom_range(1, 3);
      for (int i = 0; i < cells; i++) begin
         site.cell_alive  = ($urandom_range(0, 3) < density);
         site.cell_colour = $urandom_range(0, 1);
         send_cell(site);
      end
      drain_frame();
   endtask

   initial begin : result_sink
      int gap;
      bit sink_burst;
      sink_burst = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || moved) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[two_colour_life_generation_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      int                         sent;
      int                         frame_no;
      int                         cells;
      logic [tclg_pkg::CFG_W-1:0] w_raw;
      logic [tclg_pkg::CFG_W-1:0] h_raw;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero width and height fall back to one, and a zero seed to 0xACE1
      configure(6'd0, 6'd0, 16'h0000, 1'b1);
      send_cell(tclg_pkg::req_type'(2'b11));
      drain_frame();

      configure(6'd3, 6'd3, 16'h0001, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_cell(tclg_pkg::req_type'(MIXED_3X3[17 - 2*i -: 2]));
      end
      drain_frame();

      // overcrowded frame, lfsr carried over
      configure(6'd3, 6'd3, 16'h0000, 1'b0);
      for (int i = 0; i < 9; i++) send_cell(tclg_pkg::req_type'(2'b11));
      drain_frame();

      sent     = 0;
      frame_no = 0;
      while (sent < RANDOM_CELLS) begin
         case (frame_no)
            0: begin
               configure(6'($urandom_range(33, 63)), 6'd2, 16'hFFFF, 1'b1);
               cells      = 64;
               hold_rsp   = 1'b1;
               send_burst = 1'b1;
            end
            1: begin
               configure(6'd1, 6'($urandom_range(33, 63)), 16'h0000, 1'b0);
               cells = 32;
            end
            2: begin
               configure(6'd32, 6'd1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
               cells = 32;
            end
            default: begin
               w_raw = 6'($urandom_range(0, 8));
               h_raw = 6'($urandom_range(0, 8));
               configure(w_raw, h_raw, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
               cells = ((w_raw == 0) ? 1 : int'(w_raw)) * ((h_raw == 0) ? 1 : int'(h_raw));
            end
         endcase
         random_frame(cells);
         sent += cells;
         frame_no++;
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("[two_colour_life_generation_core] OK");
      end else begin
         $display("[two_colour_life_generation_core] ERROR");
      end
      $finish;
   end

endmodule
